// ===== rtl/adam_pkg.sv =====
// Shared types, widths and constants of the Adam update engine.
package adam_pkg;

   // Moment stores
   localparam int PARAM_COUNT = 65536;
   localparam int MEM_AW      = $clog2(PARAM_COUNT);
   localparam logic [MEM_AW-1:0] MEM_LAST = MEM_AW'(PARAM_COUNT - 1);

   // Q8.24 fixed point
   localparam int FRAC_BITS = 24;

   // Decay step sizes: 0.1 and 0.001 in Q.FRAC_BITS, rounded
   localparam logic [20:0] KM = 21'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
   localparam logic [14:0] KV = 15'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

   // Field and datapath widths
   localparam int IDX_W    = 16;
   localparam int DATA_W   = 32;
   localparam int V_W      = 40;
   localparam int GSQ_W    = 39;
   localparam int VHAT_W   = 51;
   localparam int ROOT_W   = 38;
   localparam int ABS_W    = 36;
   localparam int MAG_W    = 60;
   localparam int DVD_W    = 61;
   localparam int DEN_W    = 39;

   localparam logic [V_W-1:0] V_MAX = '1;

   // Control registers
   localparam int LR_W      = 25;
   localparam int FMC_W     = 20;
   localparam int SMC_W     = 26;
   localparam int CSR_W     = 26;
   localparam int CSR_IDX_W = 2;

   localparam logic [LR_W-1:0]  LR_RESET  = 25'd16777;
   localparam logic [FMC_W-1:0] FMC_RESET = 20'd655360;
   localparam logic [SMC_W-1:0] SMC_RESET = 26'd65536000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEARN_RATE  = 2'd0,
      CSR_FIRST_CORR  = 2'd1,
      CSR_SECOND_CORR = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [IDX_W-1:0]         elem_index;
      logic signed [DATA_W-1:0] gradient;
      logic signed [DATA_W-1:0] param_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] new_param;
      logic [IDX_W-1:0]         out_index;
   } rsp_type;

   // Updated moments leaving the store stage
   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] m_new;
      logic [V_W-1:0]           v_new;
      logic signed [DATA_W-1:0] param;
      logic [IDX_W-1:0]         idx;
   } mom_out_type;

   // Sideband through the square root pipe
   typedef struct packed {
      logic [MAG_W-1:0]         mag;
      logic                     neg;
      logic signed [DATA_W-1:0] param;
      logic [IDX_W-1:0]         idx;
   } sq_side_type;

   // Sideband through the divider pipe
   typedef struct packed {
      logic                     neg;
      logic signed [DATA_W-1:0] param;
      logic [IDX_W-1:0]         idx;
   } dv_side_type;

endpackage

// ===== rtl/adam_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module adam_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/adam_moment.sv =====
// Moment stores with read-modify-write, forwarding and post-reset clear.
module adam_moment (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_fire,
   input  adam_pkg::req_type     in_data,
   output logic                  clear_busy,
   output adam_pkg::mom_out_type out
);

   typedef struct packed {
      logic                                   valid;
      logic                                   inrange;
      logic [adam_pkg::IDX_W-1:0]             idx;
      logic signed [adam_pkg::DATA_W-1:0]     g;
      logic signed [adam_pkg::DATA_W-1:0]     p;
      logic [adam_pkg::GSQ_W-1:0]             gsq;
   } s1_type;

   typedef struct packed {
      logic                                   valid;
      logic                                   inrange;
      logic [adam_pkg::IDX_W-1:0]             idx;
      logic signed [adam_pkg::DATA_W-1:0]     p;
      logic signed [adam_pkg::DATA_W-1:0]     m;
      logic [adam_pkg::V_W-1:0]               v;
      logic signed [54:0]                     pm;
      logic signed [56:0]                     pv;
   } s2_type;

   typedef struct packed {
      logic                                   valid;
      logic                                   inrange;
      logic [adam_pkg::IDX_W-1:0]             idx;
      logic signed [adam_pkg::DATA_W-1:0]     p;
      logic signed [adam_pkg::DATA_W-1:0]     m_new;
      logic [adam_pkg::V_W-1:0]               v_new;
   } s3_type;

   localparam logic signed [54:0] PM_HALF = 55'sd1 <<< (adam_pkg::FRAC_BITS - 1);
   localparam logic signed [56:0] PV_HALF = 57'sd1 <<< (adam_pkg::FRAC_BITS - 1);
   localparam logic [63:0]        SQ_HALF = 64'd1 << (adam_pkg::FRAC_BITS - 1);
   localparam logic signed [33:0] M_MAX   = 34'sd2147483647;
   localparam logic signed [33:0] M_MIN   = -34'sd2147483648;
   localparam logic signed [21:0] KM_S    = {1'b0, adam_pkg::KM};

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;

   logic                           clr_busy_ff, clr_busy_in;
   logic [adam_pkg::MEM_AW-1:0]    clr_addr_ff, clr_addr_in;

   logic signed [63:0]             g_sq_w;
   logic [63:0]                    g_sq_r;

   logic [adam_pkg::DATA_W-1:0]    m_rdata;
   logic [adam_pkg::V_W-1:0]       v_rdata;
   logic signed [adam_pkg::DATA_W-1:0] m_cur;
   logic [adam_pkg::V_W-1:0]       v_cur;
   logic signed [32:0]             diff_m;
   logic signed [54:0]             pm_w;
   logic [53:0]                    kv_gsq;
   logic [54:0]                    kv_v;

   logic signed [54:0]             pm_r;
   logic signed [30:0]             dm;
   logic signed [33:0]             m_sum;
   logic signed [adam_pkg::DATA_W-1:0] m_new_w;
   logic signed [56:0]             pv_r;
   logic signed [32:0]             dv;
   logic signed [41:0]             v_sum;
   logic [adam_pkg::V_W-1:0]       v_new_w;

   logic                           wr_en;
   logic [adam_pkg::MEM_AW-1:0]    wr_addr;
   logic [adam_pkg::DATA_W-1:0]    m_wdata;
   logic [adam_pkg::V_W-1:0]       v_wdata;

   // Gradient square rounded to Q.24 before entering stage 1
   assign g_sq_w = in_data.gradient * in_data.gradient;
   assign g_sq_r = $unsigned(g_sq_w) + SQ_HALF;

   always_comb begin
      s1_in.valid   = in_fire;
      s1_in.inrange = {1'b0, in_data.elem_index} < 17'(adam_pkg::PARAM_COUNT);
      s1_in.idx     = in_data.elem_index;
      s1_in.g       = in_data.gradient;
      s1_in.p       = in_data.param_value;
      s1_in.gsq     = g_sq_r[62:adam_pkg::FRAC_BITS];
   end

   // Stage 1: read data arrives; newer in-flight updates win
   always_comb begin
      m_cur = s1_ff.inrange ? $signed(m_rdata) : '0;
      v_cur = s1_ff.inrange ? v_rdata : '0;
      if (s2_ff.valid && s2_ff.inrange && (s2_ff.idx == s1_ff.idx)) begin
         m_cur = m_new_w;
         v_cur = v_new_w;
      end else if (s3_ff.valid && s3_ff.inrange && (s3_ff.idx == s1_ff.idx)) begin
         m_cur = s3_ff.m_new;
         v_cur = s3_ff.v_new;
      end
   end

   assign diff_m = s1_ff.g - m_cur;
   assign pm_w   = diff_m * KM_S;
   assign kv_gsq = s1_ff.gsq * adam_pkg::KV;
   assign kv_v   = v_cur * adam_pkg::KV;

   always_comb begin
      s2_in.valid   = s1_ff.valid;
      s2_in.inrange = s1_ff.inrange;
      s2_in.idx     = s1_ff.idx;
      s2_in.p       = s1_ff.p;
      s2_in.m       = m_cur;
      s2_in.v       = v_cur;
      s2_in.pm      = pm_w;
      s2_in.pv      = $signed({3'b000, kv_gsq}) - $signed({2'b00, kv_v});
   end

   // Stage 2: round, accumulate, saturate
   assign pm_r  = s2_ff.pm + PM_HALF;
   assign dm    = pm_r[54:adam_pkg::FRAC_BITS];
   assign m_sum = s2_ff.m + dm;
   assign pv_r  = s2_ff.pv + PV_HALF;
   assign dv    = pv_r[56:adam_pkg::FRAC_BITS];
   assign v_sum = $signed({2'b00, s2_ff.v}) + dv;

   always_comb begin
      if (m_sum > M_MAX) begin
         m_new_w = M_MAX[31:0];
      end else if (m_sum < M_MIN) begin
         m_new_w = M_MIN[31:0];
      end else begin
         m_new_w = m_sum[31:0];
      end
      if (v_sum < 42'sd0) begin
         v_new_w = '0;
      end else if (v_sum > $signed({2'b00, adam_pkg::V_MAX})) begin
         v_new_w = adam_pkg::V_MAX;
      end else begin
         v_new_w = v_sum[39:0];
      end
   end

   always_comb begin
      s3_in.valid   = s2_ff.valid;
      s3_in.inrange = s2_ff.inrange;
      s3_in.idx     = s2_ff.idx;
      s3_in.p       = s2_ff.p;
      s3_in.m_new   = m_new_w;
      s3_in.v_new   = v_new_w;
   end

   // Clear sweep owns the write port after reset
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == adam_pkg::MEM_LAST) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   assign wr_en   = clr_busy_ff || (adv && s2_ff.valid && s2_ff.inrange);
   assign wr_addr = clr_busy_ff ? clr_addr_ff : s2_ff.idx[adam_pkg::MEM_AW-1:0];
   assign m_wdata = clr_busy_ff ? '0 : m_new_w;
   assign v_wdata = clr_busy_ff ? '0 : v_new_w;

   adam_ram #(.WIDTH(adam_pkg::DATA_W), .DEPTH(adam_pkg::PARAM_COUNT)) u_m_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (m_wdata),
      .rd_en   (adv),
      .rd_addr (in_data.elem_index[adam_pkg::MEM_AW-1:0]),
      .rd_data (m_rdata)
   );

   adam_ram #(.WIDTH(adam_pkg::V_W), .DEPTH(adam_pkg::PARAM_COUNT)) u_v_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (v_wdata),
      .rd_en   (adv),
      .rd_addr (in_data.elem_index[adam_pkg::MEM_AW-1:0]),
      .rd_data (v_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
         if (adv) begin
            s1_ff <= s1_in;
            s2_ff <= s2_in;
            s3_ff <= s3_in;
         end
      end
   end

   assign clear_busy = clr_busy_ff;

   always_comb begin
      out.valid = s3_ff.valid;
      out.m_new = s3_ff.m_new;
      out.v_new = s3_ff.v_new;
      out.param = s3_ff.p;
      out.idx   = s3_ff.idx;
   end

endmodule

// ===== rtl/adam_sqrt.sv =====
// Pipelined restoring square root of vhat * 2^24, one root bit per stage.
module adam_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           in_valid,
   input  logic [adam_pkg::VHAT_W-1:0]    in_vhat,
   input  adam_pkg::sq_side_type          in_side,
   output logic                           out_valid,
   output logic [adam_pkg::ROOT_W-1:0]    out_root,
   output adam_pkg::sq_side_type          out_side
);

   localparam int STEPS = adam_pkg::ROOT_W;
   localparam int X_W   = 2 * STEPS;
   localparam int REM_W = adam_pkg::ROOT_W + 2;

   typedef struct packed {
      logic                          valid;
      logic [adam_pkg::ROOT_W-1:0]   root;
      logic [REM_W-1:0]              rem;
      logic [adam_pkg::VHAT_W-1:0]   vhat;
      adam_pkg::sq_side_type         side;
   } sq_stage_type;

   sq_stage_type stage_ff [STEPS];
   sq_stage_type stage_in [STEPS];
   sq_stage_type src      [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [X_W-1:0]   x_w;
      logic [1:0]       pair_w;
      logic [REM_W-1:0] rem_sh_w;
      logic [REM_W-1:0] trial_w;

      if (k == 0) begin : g_head
         always_comb begin
            src[k]       = '0;
            src[k].valid = in_valid;
            src[k].vhat  = in_vhat;
            src[k].side  = in_side;
         end
      end else begin : g_body
         assign src[k] = stage_ff[k-1];
      end

      assign x_w      = {1'b0, src[k].vhat, {adam_pkg::FRAC_BITS{1'b0}}};
      assign pair_w   = x_w[X_W-1-2*k -: 2];
      // remainder never exceeds 2 * root, so its top two bits are always zero
      assign rem_sh_w = {src[k].rem[REM_W-3:0], pair_w};
      assign trial_w  = {src[k].root, 2'b01};

      always_comb begin
         stage_in[k] = src[k];
         if (rem_sh_w >= trial_w) begin
            stage_in[k].rem  = rem_sh_w - trial_w;
            stage_in[k].root = {src[k].root[adam_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            stage_in[k].rem  = rem_sh_w;
            stage_in[k].root = {src[k].root[adam_pkg::ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[k].valid <= 1'b0;
         end else if (adv) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign out_valid = stage_ff[STEPS-1].valid;
   assign out_root  = stage_ff[STEPS-1].root;
   assign out_side  = stage_ff[STEPS-1].side;

endmodule

// ===== rtl/adam_div.sv =====
// Pipelined restoring divider: rounded |num| / (root + 1), one quotient bit per stage.
module adam_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           in_valid,
   input  logic [adam_pkg::ROOT_W-1:0]    in_root,
   input  adam_pkg::sq_side_type          in_side,
   output logic                           out_valid,
   output logic [adam_pkg::DVD_W-1:0]     out_quot,
   output adam_pkg::dv_side_type          out_side
);

   localparam int STEPS = adam_pkg::DVD_W;

   typedef struct packed {
      logic                          valid;
      logic [adam_pkg::DEN_W-1:0]    den;
      logic [adam_pkg::DEN_W-1:0]    rem;
      logic [adam_pkg::DVD_W-1:0]    dvd;
      adam_pkg::dv_side_type         side;
   } dv_stage_type;

   dv_stage_type prep_ff, prep_in;
   dv_stage_type stage_ff [STEPS];
   dv_stage_type stage_in [STEPS];
   dv_stage_type src      [STEPS];

   // den = root + 1; dividend gets den/2 added for round-to-nearest
   always_comb begin
      prep_in.valid      = in_valid;
      prep_in.den        = {1'b0, in_root} + 1'b1;
      prep_in.rem        = '0;
      prep_in.dvd        = {1'b0, in_side.mag}
                         + {{(adam_pkg::DVD_W - adam_pkg::ROOT_W + 1){1'b0}},
                            in_root[adam_pkg::ROOT_W-1:1]}
                         + {{(adam_pkg::DVD_W - 1){1'b0}}, in_root[0]};
      prep_in.side.neg   = in_side.neg;
      prep_in.side.param = in_side.param;
      prep_in.side.idx   = in_side.idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff.valid <= 1'b0;
      end else if (adv) begin
         prep_ff <= prep_in;
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [adam_pkg::DEN_W:0] rem_sh_w;
      logic [adam_pkg::DEN_W:0] diff_w;
      logic                     fit_w;

      if (k == 0) begin : g_head
         assign src[k] = prep_ff;
      end else begin : g_body
         assign src[k] = stage_ff[k-1];
      end

      assign rem_sh_w = {src[k].rem, src[k].dvd[adam_pkg::DVD_W-1]};
      assign fit_w    = rem_sh_w >= {1'b0, src[k].den};
      assign diff_w   = rem_sh_w - {1'b0, src[k].den};

      always_comb begin
         stage_in[k]     = src[k];
         stage_in[k].dvd = {src[k].dvd[adam_pkg::DVD_W-2:0], fit_w};
         stage_in[k].rem = fit_w ? diff_w[adam_pkg::DEN_W-1:0]
                                 : rem_sh_w[adam_pkg::DEN_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[k].valid <= 1'b0;
         end else if (adv) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign out_valid = stage_ff[STEPS-1].valid;
   assign out_quot  = stage_ff[STEPS-1].dvd;
   assign out_side  = stage_ff[STEPS-1].side;

endmodule

// ===== rtl/adam_optimizer_update.sv =====
// Top level of the element-wise Adam update engine.
//
// Usage:
//  - req_* carries one transaction per element: index, gradient, current value
//    (signed Q8.24). rsp_* returns the updated value and the same index.
//  - csr_* is a write-only port: index 0 learning rate, 1 first moment
//    correction, 2 second moment correction. Write only while the engine is
//    drained; writes at any other index are dropped.
//  - Throughput: one transaction per clock outside stalls and the reset sweep,
//    any index order, repeats included. Back-to-back hits on the same element
//    are forwarded from the update stages, so no bubbles are inserted.
//  - Pipeline: the sqrt (38 stages, one root bit each) and the divider (61
//    stages, one quotient bit each) make up most of its depth.
//  - Reset: control registers load their defaults and both moment memories
//    are swept to zero, one entry per cycle, all 65536 entries. req_ready stays
//    low during the sweep; csr writes are taken as usual.
//  - Stall: the pipeline holds as a whole while a result waits on a low
//    rsp_ready; req_ready drops in the same cycle and rises again with it.
module adam_optimizer_update (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  adam_pkg::req_type                 req_data,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output adam_pkg::rsp_type                 rsp_data,

   input  logic                              csr_wr_en,
   input  logic [adam_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [adam_pkg::CSR_W-1:0]        csr_wdata
);

   // Stage 4: bias-correction products
   typedef struct packed {
      logic                                valid;
      logic [adam_pkg::IDX_W-1:0]          idx;
      logic signed [adam_pkg::DATA_W-1:0]  p;
      logic signed [52:0]                  pm;
      logic [49:0]                         pvh;
      logic [55:0]                         pvl;
   } s4_type;

   // Stage 5: mhat magnitude/sign and vhat
   typedef struct packed {
      logic                                valid;
      logic [adam_pkg::IDX_W-1:0]          idx;
      logic signed [adam_pkg::DATA_W-1:0]  p;
      logic                                neg;
      logic [adam_pkg::ABS_W-1:0]          mabs;
      logic [adam_pkg::VHAT_W-1:0]         vhat;
   } s5_type;

   localparam logic signed [52:0] MH_HALF = 53'sd32768;
   localparam logic [56:0]        VL_HALF = 57'd32768;
   localparam logic signed [62:0] R_MAX   = 63'sd2147483647;
   localparam logic signed [62:0] R_MIN   = -63'sd2147483648;

   // control registers
   logic [adam_pkg::LR_W-1:0]   lr_ff;
   logic [adam_pkg::FMC_W-1:0]  fmc_ff;
   logic [adam_pkg::SMC_W-1:0]  smc_ff;

   logic                        adv;
   logic                        req_fire;
   logic                        clear_busy;
   adam_pkg::mom_out_type       mom;

   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;

   logic signed [20:0]          fmc_s;
   logic signed [52:0]          mh_r;
   logic signed [36:0]          mhat;
   logic signed [36:0]          mhat_neg;
   logic [56:0]                 pvl_r;
   logic [60:0]                 num_mag;

   adam_pkg::sq_side_type       sq_side;
   logic                        sq_valid;
   logic [adam_pkg::ROOT_W-1:0] sq_root;
   adam_pkg::sq_side_type       sq_out_side;

   logic                        dv_valid;
   logic [adam_pkg::DVD_W-1:0]  dv_quot;
   adam_pkg::dv_side_type       dv_side;

   logic signed [61:0]          q_s;
   logic signed [61:0]          step_w;
   logic signed [62:0]          res_w;
   logic signed [adam_pkg::DATA_W-1:0] res_sat;

   logic                        rsp_valid_ff, rsp_valid_in;
   adam_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   // The whole pipe moves unless a finished result is being held.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv && !clear_busy;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff  <= adam_pkg::LR_RESET;
         fmc_ff <= adam_pkg::FMC_RESET;
         smc_ff <= adam_pkg::SMC_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            adam_pkg::CSR_LEARN_RATE:  lr_ff  <= csr_wdata[adam_pkg::LR_W-1:0];
            adam_pkg::CSR_FIRST_CORR:  fmc_ff <= csr_wdata[adam_pkg::FMC_W-1:0];
            adam_pkg::CSR_SECOND_CORR: smc_ff <= csr_wdata[adam_pkg::SMC_W-1:0];
            default: ;
         endcase
      end
   end

   // Stages 1-3: moment read, update, write-back
   adam_moment u_moment (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_fire    (req_fire),
      .in_data    (req_data),
      .clear_busy (clear_busy),
      .out        (mom)
   );

   // Stage 4: m' * fmc, and v' * smc split into integer and fraction parts
   assign fmc_s = {1'b0, fmc_ff};

   always_comb begin
      s4_in.valid = mom.valid;
      s4_in.idx   = mom.idx;
      s4_in.p     = mom.param;
      s4_in.pm    = mom.m_new * fmc_s;
      s4_in.pvh   = mom.v_new * smc_ff[adam_pkg::SMC_W-1:16];
      s4_in.pvl   = mom.v_new * smc_ff[15:0];
   end

   // Stage 5: round mhat, split sign; vhat = int part + rounded fraction part
   assign mh_r     = s4_ff.pm + MH_HALF;
   assign mhat     = mh_r[52:16];
   assign mhat_neg = -mhat;
   assign pvl_r    = {1'b0, s4_ff.pvl} + VL_HALF;

   always_comb begin
      s5_in.valid = s4_ff.valid;
      s5_in.idx   = s4_ff.idx;
      s5_in.p     = s4_ff.p;
      s5_in.neg   = mhat[36];
      s5_in.mabs  = mhat[36] ? mhat_neg[adam_pkg::ABS_W-1:0] : mhat[adam_pkg::ABS_W-1:0];
      s5_in.vhat  = {1'b0, s4_ff.pvh} + {10'd0, pvl_r[56:16]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ff.valid <= 1'b0;
         s5_ff.valid <= 1'b0;
      end else if (adv) begin
         s4_ff <= s4_in;
         s5_ff <= s5_in;
      end
   end

   // lr * |mhat| lands in the first sqrt stage alongside the first root bit
   assign num_mag = lr_ff * s5_ff.mabs;

   always_comb begin
      sq_side.mag   = num_mag[adam_pkg::MAG_W-1:0];
      sq_side.neg   = s5_ff.neg;
      sq_side.param = s5_ff.p;
      sq_side.idx   = s5_ff.idx;
   end

   adam_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s5_ff.valid),
      .in_vhat   (s5_ff.vhat),
      .in_side   (sq_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_out_side)
   );

   adam_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_valid),
      .in_root   (sq_root),
      .in_side   (sq_out_side),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_side  (dv_side)
   );

   // Apply sign, subtract from parameter, saturate
   assign q_s    = {1'b0, dv_quot};
   assign step_w = dv_side.neg ? -q_s : q_s;
   assign res_w  = dv_side.param - step_w;

   always_comb begin
      if (res_w > R_MAX) begin
         res_sat = R_MAX[31:0];
      end else if (res_w < R_MIN) begin
         res_sat = R_MIN[31:0];
      end else begin
         res_sat = res_w[31:0];
      end
   end

   always_comb begin
      rsp_valid_in          = dv_valid;
      rsp_data_in.new_param = res_sat;
      rsp_data_in.out_index = dv_side.idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
